@@ design/threshold_beacon_locator_unit_assert.svh @@
// ----------------------------------------------------------------------------
// threshold_beacon_locator_unit assertion macros
// concurrent checks clocked on clk, disabled while rst_n is low
// ----------------------------------------------------------------------------
`ifndef THRESHOLD_BEACON_LOCATOR_UNIT_ASSERT_SVH
`define THRESHOLD_BEACON_LOCATOR_UNIT_ASSERT_SVH

// same-cycle implication
`define TBL_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define TBL_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ design/tbl_pkg.sv @@
// ----------------------------------------------------------------------------
// tbl_pkg
// shared constants and types of the threshold beacon locator
// ----------------------------------------------------------------------------
package tbl_pkg;

  localparam int PIX_W      = 8;
  localparam int ROWS_CFG_W = 7;
  localparam int COLS_CFG_W = 8;
  localparam int CFG_IDX_W  = 2;
  localparam int CENTER_W   = 9;
  localparam int AREA_W     = 14;
  localparam int CHANGE_W   = 15;
  localparam int OUT_DATA_W = 48;

  localparam logic [PIX_W-1:0]      THRESHOLD_RESET = 8'd110;
  localparam logic [ROWS_CFG_W-1:0] ROWS_RESET      = 7'd64;
  localparam logic [COLS_CFG_W-1:0] COLS_RESET      = 8'd128;
  localparam logic [CENTER_W-1:0]   MISS_CODE       = 9'd404;
  localparam logic [AREA_W-1:0]     AREA_CAP        = 14'd8192;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_THRESHOLD = 2'd0,
    CFG_ROWS      = 2'd1,
    CFG_COLS      = 2'd2
  } cfg_idx_t;

  // control sequencer
  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_DONE = 3'b100
  } state_t;

endpackage

@@ design/tbl_frame_mem.sv @@
// ----------------------------------------------------------------------------
// tbl_frame_mem
// one-bit frame store, one write port and one registered read port
// ----------------------------------------------------------------------------
module tbl_frame_mem #(
  parameter int AW    = 13,
  parameter int DEPTH = 8192
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic          wr_bit,
  input  logic [AW-1:0] rd_addr,
  output logic          rd_bit
);

  logic mem_r [0:DEPTH-1];
  logic rd_bit_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_bit;
    end
    rd_bit_r <= mem_r[rd_addr];
  end

  assign rd_bit = rd_bit_r;

endmodule

@@ design/threshold_beacon_locator_unit.sv @@
// ----------------------------------------------------------------------------
// threshold_beacon_locator_unit
// thresholds a grey raster into a bit store and locates a beacon blob
// ----------------------------------------------------------------------------
// Pixels stream in one per clock in raster order (in_tdata = grey level,
// in_tlast = last pixel of the frame) and each is thresholded into a one-bit
// frame store. The pixel marked with in_tlast starts a bottom-up scan of the
// store, from row rows_in_use-1 up to row 1, one bit per clock through the
// store's single read port; the scan ends on the first empty row after a lit
// row. When the scan ends, one result transaction is offered on the out_ side;
// no pixel is accepted from the frame end until that result is loaded into the
// output register. Rows 0 and 1 in rows_in_use give a miss with no scan. There
// is no clearing pass after reset: the store only needs to be written before it
// is read.
// ----------------------------------------------------------------------------
`include "threshold_beacon_locator_unit_assert.svh"

module threshold_beacon_locator_unit #(
  parameter int MAX_ROWS = 64,
  parameter int MAX_COLS = 128
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // input stream
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [tbl_pkg::PIX_W-1:0]           in_tdata,   // [7:0] pixel
  input  logic                                in_tlast,   // frame_end
  // result stream
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // [8:0] center_x, [17:9] center_y, [31:18] blob_area,
  // [46:32] area_change, [47] ever_found
  output logic [tbl_pkg::OUT_DATA_W-1:0]      out_tdata,
  output logic                                out_tuser,  // found
  // configuration writes
  input  logic                                cfg_we,
  input  logic [tbl_pkg::CFG_IDX_W-1:0]       cfg_idx,
  input  logic [tbl_pkg::COLS_CFG_W-1:0]      cfg_wdata
);

  localparam int RW    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int CW    = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int AW    = RW + CW;
  localparam int DEPTH = MAX_ROWS * (2 ** CW);
  localparam int EW    = tbl_pkg::COLS_CFG_W;

  // configuration registers
  logic [tbl_pkg::PIX_W-1:0]      thr_r;
  logic [tbl_pkg::ROWS_CFG_W-1:0] rows_r;
  logic [EW-1:0]                  cols_r;

  // sequencer and write position
  tbl_pkg::state_t state_r, state_nxt;
  logic [RW-1:0] wr_row_r, wr_row_nxt;
  logic [CW-1:0] wr_col_r, wr_col_nxt;

  // scan read address and the tag that rides along with the read data
  logic [RW-1:0] rd_row_r, rd_row_nxt;
  logic [CW-1:0] rd_col_r, rd_col_nxt;
  logic          iss_done_r, iss_done_nxt;
  logic          tag_vld_r, tag_vld_nxt;
  logic          tag_eol_r, tag_eol_nxt;
  logic          tag_lastrow_r, tag_lastrow_nxt;
  logic [RW-1:0] tag_row_r, tag_row_nxt;
  logic [CW-1:0] tag_col_r, tag_col_nxt;

  // scan accumulators
  logic                       hit_r, hit_nxt;
  logic [tbl_pkg::AREA_W-1:0] area_r, area_nxt;
  logic [CW-1:0]              left_r, left_nxt;
  logic [CW-1:0]              right_r, right_nxt;
  logic [RW-1:0]              top_r, top_nxt;
  logic [RW-1:0]              bot_r, bot_nxt;
  logic                       line_nz_r, line_nz_nxt;
  logic                       prev_nz_r, prev_nz_nxt;

  // frame-to-frame state
  logic [tbl_pkg::AREA_W-1:0]   last_area_r, last_area_nxt;
  logic [tbl_pkg::CHANGE_W-1:0] held_r, held_nxt;
  logic                         seen_r, seen_nxt;

  // output register
  logic                           out_tvalid_r, out_tvalid_nxt;
  logic                           out_found_r, out_found_nxt;
  logic [tbl_pkg::CENTER_W-1:0]   out_cx_r, out_cx_nxt;
  logic [tbl_pkg::CENTER_W-1:0]   out_cy_r, out_cy_nxt;
  logic [tbl_pkg::AREA_W-1:0]     out_area_r, out_area_nxt;
  logic [tbl_pkg::CHANGE_W-1:0]   out_chg_r, out_chg_nxt;
  logic                           out_ever_r, out_ever_nxt;

  // effective geometry
  logic [EW-1:0] eff_cols;
  logic [EW-1:0] eff_cols_last;
  logic [EW-1:0] eff_rows;
  logic          scan_none;
  logic [RW-1:0] row_first;
  logic          col_wrap;
  logic          rd_eol;
  logic          rd_lastrow;

  logic          in_acc;
  logic          bit_q;
  logic          lit;
  logic [CW:0]   sum_x;
  logic [RW:0]   sum_y;

  // column count 0 acts as 1, counts above the store clamp to it
  assign eff_cols = (cols_r == '0) ? EW'(1)
                  : ((cols_r > EW'(MAX_COLS)) ? EW'(MAX_COLS) : cols_r);
  assign eff_cols_last = eff_cols - EW'(1);
  assign eff_rows = ({1'b0, rows_r} > EW'(MAX_ROWS)) ? EW'(MAX_ROWS) : {1'b0, rows_r};
  assign scan_none = (eff_rows < EW'(2));
  assign row_first = RW'(eff_rows - EW'(1));

  assign col_wrap   = ({1'b0, EW'(wr_col_r)} + 9'd1) >= {1'b0, eff_cols};
  assign rd_eol     = (EW'(rd_col_r) == eff_cols_last);
  assign rd_lastrow = (rd_row_r == RW'(1));

  assign in_tready = (state_r == tbl_pkg::ST_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign lit       = (in_tdata >= thr_r);

  assign sum_x = {1'b0, left_r} + {1'b0, right_r};
  assign sum_y = {1'b0, top_r} + {1'b0, bot_r};

  tbl_frame_mem #(
    .AW    (AW),
    .DEPTH (DEPTH)
  ) u_frame_mem (
    .clk     (clk),
    .wr_en   (in_acc),
    .wr_addr ({wr_row_r, wr_col_r}),
    .wr_bit  (lit),
    .rd_addr ({rd_row_r, rd_col_r}),
    .rd_bit  (bit_q)
  );

  // raster write position, back to the origin after the frame end pixel
  always_comb begin
    wr_row_nxt = wr_row_r;
    wr_col_nxt = wr_col_r;
    if (in_acc) begin
      if (in_tlast) begin
        wr_row_nxt = '0;
        wr_col_nxt = '0;
      end else if (col_wrap) begin
        wr_col_nxt = '0;
        wr_row_nxt = (wr_row_r == RW'(MAX_ROWS - 1)) ? '0 : wr_row_r + RW'(1);
      end else begin
        wr_col_nxt = wr_col_r + CW'(1);
      end
    end
  end

  // sequencer: issue one read a clock, process each bit in the cycle after its read
  always_comb begin
    logic line_now;
    line_now        = 1'b0;
    state_nxt       = state_r;
    rd_row_nxt      = rd_row_r;
    rd_col_nxt      = rd_col_r;
    iss_done_nxt    = iss_done_r;
    tag_vld_nxt     = tag_vld_r;
    tag_eol_nxt     = tag_eol_r;
    tag_lastrow_nxt = tag_lastrow_r;
    tag_row_nxt     = tag_row_r;
    tag_col_nxt     = tag_col_r;
    hit_nxt         = hit_r;
    area_nxt        = area_r;
    left_nxt        = left_r;
    right_nxt       = right_r;
    top_nxt         = top_r;
    bot_nxt         = bot_r;
    line_nz_nxt     = line_nz_r;
    prev_nz_nxt     = prev_nz_r;
    last_area_nxt   = last_area_r;
    held_nxt        = held_r;
    seen_nxt        = seen_r;
    out_tvalid_nxt  = out_tvalid_r && !out_tready;
    out_found_nxt   = out_found_r;
    out_cx_nxt      = out_cx_r;
    out_cy_nxt      = out_cy_r;
    out_area_nxt    = out_area_r;
    out_chg_nxt     = out_chg_r;
    out_ever_nxt    = out_ever_r;

    case (state_r)
      tbl_pkg::ST_IDLE: begin
        if (in_acc && in_tlast) begin
          hit_nxt      = 1'b0;
          area_nxt     = '0;
          line_nz_nxt  = 1'b0;
          prev_nz_nxt  = 1'b0;
          rd_row_nxt   = row_first;
          rd_col_nxt   = '0;
          iss_done_nxt = 1'b0;
          tag_vld_nxt  = 1'b0;
          state_nxt    = scan_none ? tbl_pkg::ST_DONE : tbl_pkg::ST_SCAN;
        end
      end

      tbl_pkg::ST_SCAN: begin
        // read issue
        tag_vld_nxt     = !iss_done_r;
        tag_eol_nxt     = rd_eol;
        tag_lastrow_nxt = rd_lastrow;
        tag_row_nxt     = rd_row_r;
        tag_col_nxt     = rd_col_r;
        if (!iss_done_r) begin
          if (rd_eol) begin
            rd_col_nxt = '0;
            if (rd_lastrow) begin
              iss_done_nxt = 1'b1;
            end else begin
              rd_row_nxt = rd_row_r - RW'(1);
            end
          end else begin
            rd_col_nxt = rd_col_r + CW'(1);
          end
        end

        // bit processing
        if (tag_vld_r) begin
          if (bit_q) begin
            if (!hit_r) begin
              left_nxt = tag_col_r;
              bot_nxt  = tag_row_r;
              hit_nxt  = 1'b1;
            end
            if (area_r != tbl_pkg::AREA_CAP) begin
              area_nxt = area_r + tbl_pkg::AREA_W'(1);
            end
            top_nxt   = tag_row_r;
            right_nxt = tag_col_r;
          end
          line_now    = line_nz_r | bit_q;
          line_nz_nxt = line_now;
          if (tag_eol_r) begin
            line_nz_nxt = 1'b0;
            prev_nz_nxt = line_now;
            // empty row after a lit row, or row 1 done
            if ((prev_nz_r && !line_now) || tag_lastrow_r) begin
              state_nxt   = tbl_pkg::ST_DONE;
              tag_vld_nxt = 1'b0;
            end
          end
        end
      end

      tbl_pkg::ST_DONE: begin
        if (!out_tvalid_r || out_tready) begin
          out_tvalid_nxt = 1'b1;
          out_found_nxt  = hit_r;
          if (hit_r) begin
            held_nxt      = tbl_pkg::CHANGE_W'(area_r) - tbl_pkg::CHANGE_W'(last_area_r);
            last_area_nxt = area_r;
            seen_nxt      = 1'b1;
            out_cx_nxt    = tbl_pkg::CENTER_W'(sum_x[CW:1]);
            out_cy_nxt    = tbl_pkg::CENTER_W'(sum_y[RW:1]);
            out_area_nxt  = area_r;
            out_chg_nxt   = tbl_pkg::CHANGE_W'(area_r) - tbl_pkg::CHANGE_W'(last_area_r);
            out_ever_nxt  = 1'b1;
          end else begin
            // miss: sentinels, change held from the last hit
            last_area_nxt = '0;
            out_cx_nxt    = tbl_pkg::MISS_CODE;
            out_cy_nxt    = tbl_pkg::MISS_CODE;
            out_area_nxt  = '0;
            out_chg_nxt   = held_r;
            out_ever_nxt  = seen_r;
          end
          state_nxt = tbl_pkg::ST_IDLE;
        end
      end

      default: begin
        state_nxt = tbl_pkg::ST_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r        <= tbl_pkg::THRESHOLD_RESET;
      rows_r       <= tbl_pkg::ROWS_RESET;
      cols_r       <= tbl_pkg::COLS_RESET;
      state_r      <= tbl_pkg::ST_IDLE;
      wr_row_r     <= '0;
      wr_col_r     <= '0;
      iss_done_r   <= 1'b0;
      tag_vld_r    <= 1'b0;
      last_area_r  <= '0;
      held_r       <= '0;
      seen_r       <= 1'b0;
      out_tvalid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_idx)
          tbl_pkg::CFG_THRESHOLD: thr_r  <= cfg_wdata;
          tbl_pkg::CFG_ROWS:      rows_r <= cfg_wdata[tbl_pkg::ROWS_CFG_W-1:0];
          tbl_pkg::CFG_COLS:      cols_r <= cfg_wdata;
          default: begin
          end
        endcase
      end
      state_r      <= state_nxt;
      wr_row_r     <= wr_row_nxt;
      wr_col_r     <= wr_col_nxt;
      iss_done_r   <= iss_done_nxt;
      tag_vld_r    <= tag_vld_nxt;
      last_area_r  <= last_area_nxt;
      held_r       <= held_nxt;
      seen_r       <= seen_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  // datapath, no reset needed
  always_ff @(posedge clk) begin
    rd_row_r      <= rd_row_nxt;
    rd_col_r      <= rd_col_nxt;
    tag_eol_r     <= tag_eol_nxt;
    tag_lastrow_r <= tag_lastrow_nxt;
    tag_row_r     <= tag_row_nxt;
    tag_col_r     <= tag_col_nxt;
    hit_r         <= hit_nxt;
    area_r        <= area_nxt;
    left_r        <= left_nxt;
    right_r       <= right_nxt;
    top_r         <= top_nxt;
    bot_r         <= bot_nxt;
    line_nz_r     <= line_nz_nxt;
    prev_nz_r     <= prev_nz_nxt;
    out_found_r   <= out_found_nxt;
    out_cx_r      <= out_cx_nxt;
    out_cy_r      <= out_cy_nxt;
    out_area_r    <= out_area_nxt;
    out_chg_r     <= out_chg_nxt;
    out_ever_r    <= out_ever_nxt;
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tuser  = out_found_r;
  assign out_tdata  = {out_ever_r, out_chg_r, out_area_r, out_cy_r, out_cx_r};

  // a found result always carries a nonzero area
  `TBL_ASSERT_IMP(a_found_area, out_tvalid && out_tuser, out_area_r != '0, "found with zero area")
  // a miss carries both sentinels and zero area
  `TBL_ASSERT_IMP(a_miss_code, out_tvalid && !out_tuser, (out_cx_r == tbl_pkg::MISS_CODE) && (out_cy_r == tbl_pkg::MISS_CODE) && (out_area_r == '0), "miss without sentinels")
  // area counter saturates
  `TBL_ASSERT_IMP(a_area_cap, state_r != tbl_pkg::ST_IDLE, area_r <= tbl_pkg::AREA_CAP, "area above cap")
  // ever-found flag is sticky
  `TBL_ASSERT_NXT(a_seen_sticky, seen_r, seen_r, "ever-found flag dropped")
  // finishing row 1 always ends the scan
  `TBL_ASSERT_NXT(a_scan_end, (state_r == tbl_pkg::ST_SCAN) && tag_vld_r && tag_eol_r && tag_lastrow_r, state_r == tbl_pkg::ST_DONE, "scan ran past row 1")

endmodule
